[design/ppcv_pkg.sv]
`default_nettype none

package ppcv_pkg;

    // Field and register widths
    localparam int SAMPLE_W   = 18;
    localparam int TARGET_W   = 18;
    localparam int GAIN_W     = 24;
    localparam int ALPHA_W    = 17;
    localparam int LEVEL_W    = 10;
    localparam int VENT_W     = 13;
    localparam int MODE_W     = 3;
    localparam int WRAP_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // Internal datapath widths
    localparam int FILT_W  = 26;
    localparam int ACC_W   = 44;
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 26;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int DRIVE_W = 16;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA  = 2'd2;

    // Constants of the control law
    localparam logic [SAMPLE_W-1:0] OVERPRESSURE_PA = 18'd90000;
    localparam logic [TARGET_W-1:0] MIN_TARGET_PA   = 18'd100;
    localparam logic [VENT_W-1:0]   VENT_MAX_US     = 13'd7000;
    localparam logic [VENT_W-1:0]   VENT_MIN_US     = 13'd50;
    localparam logic [DRIVE_W-1:0]  DRIVE_ONE       = 16'd32768;
    localparam logic [ALPHA_W-1:0]  ALPHA_ONE       = 17'd65536;
    localparam logic [ALPHA_W-1:0]  ALPHA_RESET     = 17'd32768;
    localparam logic [ACC_W-1:0]    ROUND_HALF      = 44'd32768;

    typedef enum logic [MODE_W-1:0] {
        MODE_OVER = 3'd0,
        MODE_IDLE = 3'd1,
        MODE_PUMP = 3'd2,
        MODE_HOLD = 3'd3,
        MODE_VENT = 3'd4
    } mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL_A,
        ST_MUL_B,
        ST_EMA,
        ST_ERR,
        ST_MUL_G,
        ST_DRIVE,
        ST_MUL_L,
        ST_MUL_V,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_ALPHA_NEW,
        MUL_ALPHA_OLD,
        MUL_GAIN,
        MUL_LEVEL,
        MUL_VENT
    } mul_sel_t;

    typedef struct packed {
        logic     load_sample;
        logic     prime;
        mul_sel_t mul_sel;
        logic     acc_load;
        logic     filt_load;
        logic     err_load;
        logic     mag_load;
        logic     result_load;
        mode_t    mode;
    } cmd_t;

    typedef struct packed {
        logic over;
        logic mag_zero;
        logic negative;
        logic vent_short;
    } sts_t;

endpackage

`default_nettype wire

[design/ppcv_ctrl.sv]
`default_nettype none

// Sequencer: walks one sample through the shared multiplier and hands the
// finished word to the output register.
module ppcv_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    input  wire ppcv_pkg::sts_t sts,
    output ppcv_pkg::cmd_t     cmd
);

    ppcv_pkg::state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic can_emit;

    assign can_emit = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ppcv_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ppcv_pkg::ST_IDLE:  if (s_tvalid) state_next = ppcv_pkg::ST_CHECK;
            ppcv_pkg::ST_CHECK: begin
                state_next = sts.over ? ppcv_pkg::ST_DONE : ppcv_pkg::ST_MUL_A;
            end
            ppcv_pkg::ST_MUL_A: state_next = ppcv_pkg::ST_MUL_B;
            ppcv_pkg::ST_MUL_B: state_next = ppcv_pkg::ST_EMA;
            ppcv_pkg::ST_EMA:   state_next = ppcv_pkg::ST_ERR;
            ppcv_pkg::ST_ERR:   state_next = ppcv_pkg::ST_MUL_G;
            ppcv_pkg::ST_MUL_G: state_next = ppcv_pkg::ST_DRIVE;
            ppcv_pkg::ST_DRIVE: state_next = ppcv_pkg::ST_MUL_L;
            ppcv_pkg::ST_MUL_L: begin
                if (sts.mag_zero || !sts.negative) begin
                    state_next = ppcv_pkg::ST_DONE;
                end else begin
                    state_next = ppcv_pkg::ST_MUL_V;
                end
            end
            ppcv_pkg::ST_MUL_V: state_next = ppcv_pkg::ST_DONE;
            ppcv_pkg::ST_DONE:  if (can_emit) state_next = ppcv_pkg::ST_IDLE;
            default:            state_next = ppcv_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd            = '0;
        cmd.mul_sel    = ppcv_pkg::MUL_NONE;
        cmd.mode       = ppcv_pkg::MODE_IDLE;
        s_tready       = 1'b0;
        out_valid_next = out_valid_reg && !m_tready;
        unique case (state_reg)
            ppcv_pkg::ST_IDLE: begin
                s_tready        = 1'b1;
                cmd.load_sample = s_tvalid;
            end
            ppcv_pkg::ST_CHECK: cmd.prime = !sts.over;
            ppcv_pkg::ST_MUL_A: cmd.mul_sel = ppcv_pkg::MUL_ALPHA_NEW;
            ppcv_pkg::ST_MUL_B: begin
                cmd.mul_sel  = ppcv_pkg::MUL_ALPHA_OLD;
                cmd.acc_load = 1'b1;
            end
            ppcv_pkg::ST_EMA:   cmd.filt_load = 1'b1;
            ppcv_pkg::ST_ERR:   cmd.err_load = 1'b1;
            ppcv_pkg::ST_MUL_G: cmd.mul_sel = ppcv_pkg::MUL_GAIN;
            ppcv_pkg::ST_DRIVE: cmd.mag_load = 1'b1;
            ppcv_pkg::ST_MUL_L: cmd.mul_sel = ppcv_pkg::MUL_LEVEL;
            ppcv_pkg::ST_MUL_V: cmd.mul_sel = ppcv_pkg::MUL_VENT;
            ppcv_pkg::ST_DONE: begin
                if (sts.over) begin
                    cmd.mode = ppcv_pkg::MODE_OVER;
                end else if (sts.mag_zero) begin
                    cmd.mode = ppcv_pkg::MODE_IDLE;
                end else if (!sts.negative) begin
                    cmd.mode = ppcv_pkg::MODE_PUMP;
                end else if (sts.vent_short) begin
                    cmd.mode = ppcv_pkg::MODE_HOLD;
                end else begin
                    cmd.mode = ppcv_pkg::MODE_VENT;
                end
                if (can_emit) begin
                    cmd.result_load = 1'b1;
                    out_valid_next  = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = out_valid_reg;

endmodule

`default_nettype wire

[design/ppcv_datapath.sv]
`default_nettype none

// Configuration registers, filter state, one shared multiplier with its
// product register, and the output word register.
module ppcv_datapath #(
    parameter int unsigned PWM_WRAP = 1000
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [ppcv_pkg::CFG_IDX_W-1:0]      cfg_wr_index,
    input  wire logic [ppcv_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    input  wire logic [ppcv_pkg::SAMPLE_W-1:0]       sample_in,
    input  wire ppcv_pkg::cmd_t                      cmd,
    output ppcv_pkg::sts_t                           sts,
    output logic [ppcv_pkg::LEVEL_W-1:0]             pump_level,
    output logic [ppcv_pkg::LEVEL_W-1:0]             valve_level,
    output logic [ppcv_pkg::VENT_W-1:0]              vent_time_us,
    output logic [ppcv_pkg::MODE_W-1:0]              mode_taken
);

    localparam logic [ppcv_pkg::WRAP_W-1:0] WRAP = ppcv_pkg::WRAP_W'(PWM_WRAP);
    localparam int LVL_RAW_W = ppcv_pkg::PROD_W - 15;

    logic [ppcv_pkg::TARGET_W-1:0] target_reg;
    logic [ppcv_pkg::GAIN_W-1:0]   gain_reg;
    logic [ppcv_pkg::ALPHA_W-1:0]  alpha_reg;

    logic [ppcv_pkg::SAMPLE_W-1:0] sample_reg;
    logic [ppcv_pkg::FILT_W-1:0]   filt_reg;
    logic                          primed_reg;
    logic [ppcv_pkg::ACC_W-1:0]    acc_reg;
    logic [ppcv_pkg::PROD_W-1:0]   p_reg, p_next;
    logic [ppcv_pkg::FILT_W-1:0]   err_reg;
    logic                          neg_reg;
    logic [ppcv_pkg::DRIVE_W-1:0]  mag_reg, mag_next;

    logic [ppcv_pkg::LEVEL_W-1:0]  pump_reg, pump_next;
    logic [ppcv_pkg::LEVEL_W-1:0]  valve_reg, valve_next;
    logic [ppcv_pkg::VENT_W-1:0]   vent_reg, vent_next;
    ppcv_pkg::mode_t               mode_reg;

    logic [ppcv_pkg::FILT_W-1:0]   fresh;
    logic [ppcv_pkg::FILT_W-1:0]   tgt_q8;
    logic [ppcv_pkg::ALPHA_W-1:0]  alpha_sat;
    logic [ppcv_pkg::ALPHA_W-1:0]  alpha_inv;
    logic [ppcv_pkg::MUL_A_W-1:0]  mul_a;
    logic [ppcv_pkg::MUL_B_W-1:0]  mul_b;
    logic [ppcv_pkg::ACC_W-1:0]    ema_sum;
    logic [ppcv_pkg::PROD_W-18:0]  drive_raw;
    logic [LVL_RAW_W-1:0]          lvl_raw;
    logic [ppcv_pkg::VENT_W-1:0]   vent_raw;

    assign fresh     = {sample_reg, 8'd0};
    assign tgt_q8    = {target_reg, 8'd0};
    assign alpha_sat = (alpha_reg > ppcv_pkg::ALPHA_ONE) ? ppcv_pkg::ALPHA_ONE : alpha_reg;
    assign alpha_inv = ppcv_pkg::ALPHA_ONE - alpha_sat;
    assign ema_sum   = acc_reg + p_reg[ppcv_pkg::ACC_W-1:0];
    assign drive_raw = p_reg[ppcv_pkg::PROD_W-1:17];
    assign lvl_raw   = p_reg[ppcv_pkg::PROD_W-1:15];
    assign vent_raw  = p_reg[30 +: ppcv_pkg::VENT_W];

    // Operand selection for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_sel)
            ppcv_pkg::MUL_ALPHA_NEW: begin
                mul_a = ppcv_pkg::MUL_A_W'(alpha_sat);
                mul_b = fresh;
            end
            ppcv_pkg::MUL_ALPHA_OLD: begin
                mul_a = ppcv_pkg::MUL_A_W'(alpha_inv);
                mul_b = filt_reg;
            end
            ppcv_pkg::MUL_GAIN: begin
                mul_a = ppcv_pkg::MUL_A_W'(gain_reg);
                mul_b = err_reg;
            end
            ppcv_pkg::MUL_LEVEL: begin
                mul_a = ppcv_pkg::MUL_A_W'(mag_reg);
                mul_b = neg_reg ? ppcv_pkg::MUL_B_W'(mag_reg) : ppcv_pkg::MUL_B_W'(WRAP);
            end
            ppcv_pkg::MUL_VENT: begin
                mul_a = {1'b0, p_reg[30:0]};
                mul_b = ppcv_pkg::MUL_B_W'(ppcv_pkg::VENT_MAX_US);
            end
            default: ;
        endcase
    end

    assign p_next = (cmd.mul_sel == ppcv_pkg::MUL_NONE) ? p_reg
                  : ppcv_pkg::PROD_W'(mul_a) * ppcv_pkg::PROD_W'(mul_b);

    always_comb begin
        if (target_reg < ppcv_pkg::MIN_TARGET_PA) begin
            mag_next = '0;
        end else if (drive_raw > (ppcv_pkg::PROD_W-17)'(ppcv_pkg::DRIVE_ONE)) begin
            mag_next = ppcv_pkg::DRIVE_ONE;
        end else begin
            mag_next = drive_raw[ppcv_pkg::DRIVE_W-1:0];
        end
    end

    // Result fields for the mode that the sequencer has chosen
    always_comb begin
        pump_next  = '0;
        valve_next = '0;
        vent_next  = '0;
        case (cmd.mode)
            ppcv_pkg::MODE_PUMP: begin
                if (lvl_raw > LVL_RAW_W'(WRAP)) begin
                    pump_next = WRAP[ppcv_pkg::LEVEL_W-1:0];
                end else begin
                    pump_next = lvl_raw[ppcv_pkg::LEVEL_W-1:0];
                end
                valve_next = WRAP[ppcv_pkg::LEVEL_W-1:0];
            end
            ppcv_pkg::MODE_HOLD: valve_next = WRAP[ppcv_pkg::LEVEL_W-1:0];
            ppcv_pkg::MODE_VENT: vent_next = vent_raw;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= '0;
            gain_reg   <= '0;
            alpha_reg  <= ppcv_pkg::ALPHA_RESET;
            filt_reg   <= '0;
            primed_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    ppcv_pkg::CFG_TARGET: target_reg <= cfg_wr_data[ppcv_pkg::TARGET_W-1:0];
                    ppcv_pkg::CFG_GAIN:   gain_reg   <= cfg_wr_data[ppcv_pkg::GAIN_W-1:0];
                    ppcv_pkg::CFG_ALPHA:  alpha_reg  <= cfg_wr_data[ppcv_pkg::ALPHA_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.prime && !primed_reg) begin
                filt_reg   <= fresh;
                primed_reg <= 1'b1;
            end else if (cmd.filt_load) begin
                filt_reg <= ema_sum[16 +: ppcv_pkg::FILT_W];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_sample) sample_reg <= sample_in;
        if (cmd.acc_load)    acc_reg    <= p_reg[ppcv_pkg::ACC_W-1:0] + ppcv_pkg::ROUND_HALF;
        p_reg <= p_next;
        if (cmd.err_load) begin
            neg_reg <= tgt_q8 < filt_reg;
            err_reg <= (tgt_q8 < filt_reg) ? filt_reg - tgt_q8 : tgt_q8 - filt_reg;
        end
        if (cmd.mag_load) mag_reg <= mag_next;
        if (cmd.result_load) begin
            pump_reg  <= pump_next;
            valve_reg <= valve_next;
            vent_reg  <= vent_next;
            mode_reg  <= cmd.mode;
        end
    end

    assign sts.over       = sample_reg > ppcv_pkg::OVERPRESSURE_PA;
    assign sts.mag_zero   = mag_reg == '0;
    assign sts.negative   = neg_reg;
    assign sts.vent_short = vent_raw < ppcv_pkg::VENT_MIN_US;

    assign pump_level   = pump_reg;
    assign valve_level  = valve_reg;
    assign vent_time_us = vent_reg;
    assign mode_taken   = mode_reg;

endmodule

`default_nettype wire

[design/pressure_p_controller_with_vent_unit.sv]
`default_nettype none

// Channel      | Direction | Payload
// -------------+-----------+---------------------------------------------------
// s_ (sample)  | in        | tdata: pressure_sample [17:0], zero padded to 24
// m_ (result)  | out       | tdata: pump_level [9:0], valve_level [19:10],
//              |           |        vent_time_us [32:20], zero padded to 40;
//              |           | tuser: mode_taken [2:0]
// cfg          | in        | write port: 0 target, 1 gain, 2 filter alpha
//
// A sample passes through the check, the filter, the error, the gain and the
// output scaling (and the vent pulse length when needed) to a result word; an
// overpressure sample goes straight to it. The steps are set by the one shared
// multiplier, which the filter, the gain and the output scaling use in turn.
// Reset is synchronous and active low; it restores the register defaults and
// clears the filter. A result word waits in the output register while the
// next sample is taken; the sequencer only stalls at its last step if that
// register is still full.
module pressure_p_controller_with_vent_unit #(
    parameter int unsigned PWM_WRAP = 1000
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // Configuration write port
    input  wire logic                            cfg_wr_en,
    input  wire logic [ppcv_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  wire logic [ppcv_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    // Sample stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [23:0]                     s_tdata,   // pressure_sample
    // Result stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [39:0]                          m_tdata,   // pump, valve, vent time
    output logic [2:0]                           m_tuser    // mode_taken
);

    ppcv_pkg::cmd_t cmd;
    ppcv_pkg::sts_t sts;

    logic [ppcv_pkg::LEVEL_W-1:0] pump_level;
    logic [ppcv_pkg::LEVEL_W-1:0] valve_level;
    logic [ppcv_pkg::VENT_W-1:0]  vent_time_us;
    logic [ppcv_pkg::MODE_W-1:0]  mode_taken;

    // The sequencer owns the handshakes and the output valid flag.
    ppcv_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath holds the settings, the filter state and the result word.
    ppcv_datapath #(
        .PWM_WRAP (PWM_WRAP)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .sample_in    (s_tdata[ppcv_pkg::SAMPLE_W-1:0]),
        .cmd          (cmd),
        .sts          (sts),
        .pump_level   (pump_level),
        .valve_level  (valve_level),
        .vent_time_us (vent_time_us),
        .mode_taken   (mode_taken)
    );

    assign m_tdata = {7'd0, vent_time_us, valve_level, pump_level};
    assign m_tuser = mode_taken;

    // Once a sample is taken the block is busy on the following cycle.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("sample taken while the previous one was still in work");

    // Loading a result word always raises the output valid flag.
    a_result_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.result_load |=> m_tvalid)
        else $error("result word loaded but not presented");

    // A vent pulse shorter than the minimum must have been turned into a hold.
    a_vent_min: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ppcv_pkg::MODE_VENT) |->
            m_tdata[32:20] >= ppcv_pkg::VENT_MIN_US)
        else $error("vent pulse below minimum length");

endmodule

`default_nettype wire
